FILE: src/gnce_pkg.sv
// ----------------------------------------------------------------------------
// gnce_pkg: shared types and constants for the grid neighbor cell enumerator
// Holds the grid limits, field widths, register indexes and the structs that
// travel between the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package gnce_pkg;

   // grid limits
   localparam int MAX_DIM   = 16;
   localparam int MAX_REACH = 1;
   localparam int NUM_AXES  = 3;

   // internal widths derived from the grid limits
   localparam int CW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW  = $clog2(MAX_DIM + 1);
   localparam int RW  = (MAX_REACH > 0) ? $clog2(MAX_REACH + 1) : 1;
   localparam int EW  = CW + 2;
   localparam int AXW = $clog2(NUM_AXES);

   // field and register widths
   localparam int POS_W      = 24;
   localparam int SCALE_W    = 24;
   localparam int RAD_W      = POS_W + 1;
   localparam int FRAC_W     = 24;
   localparam int PROD_W     = RAD_W + SCALE_W;
   localparam int DIM_REG_W  = 5;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int ID_W       = 12;
   localparam int COORD_W    = 4;

   // front sequencer: one multiply per axis for the cell and one for the reach
   localparam int NUM_STEPS = 2 * NUM_AXES;
   localparam int STEP_W    = $clog2(NUM_STEPS + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // axis positions
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // register reset values
   localparam logic [DIM_REG_W-1:0] DIM_X_RST = DIM_REG_W'(16);
   localparam logic [DIM_REG_W-1:0] DIM_Y_RST = DIM_REG_W'(16);
   localparam logic [DIM_REG_W-1:0] DIM_Z_RST = DIM_REG_W'(0);
   localparam logic [SCALE_W-1:0]   SCALE_RST = SCALE_W'(65536);
   localparam logic [SCALE_W-1:0]   GUARD_RST = SCALE_W'(0);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIM_X   = 3'd0,
      REG_DIM_Y   = 3'd1,
      REG_DIM_Z   = 3'd2,
      REG_SCALE_X = 3'd3,
      REG_SCALE_Y = 3'd4,
      REG_SCALE_Z = 3'd5,
      REG_GUARD   = 3'd6
   } csr_reg_type;

   // configuration as seen by the front and back, dims already clamped
   typedef struct packed {
      logic [NUM_AXES-1:0][DW-1:0]      dim;
      logic [NUM_AXES-1:0][SCALE_W-1:0] scale;
      logic [SCALE_W-1:0]               guard;
   } cfg_type;

   // clamped cell box of one query
   typedef struct packed {
      logic [NUM_AXES-1:0][CW-1:0] lo;
      logic [NUM_AXES-1:0][CW-1:0] hi;
   } box_type;

endpackage

`default_nettype wire

FILE: src/gnce_front.sv
// ----------------------------------------------------------------------------
// gnce_front: query intake and box setup
// Takes one query, runs six multiplies through one shared multiplier (cell
// index and reach for each axis), clamps them and pushes the cell box.
// ----------------------------------------------------------------------------
`default_nettype none

module gnce_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire gnce_pkg::cfg_type              cfg,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire [gnce_pkg::POS_W-1:0]           req_pos_x,
   input  wire [gnce_pkg::POS_W-1:0]           req_pos_y,
   input  wire [gnce_pkg::POS_W-1:0]           req_pos_z,
   input  wire [gnce_pkg::POS_W-1:0]           req_reach_range,
   input  wire                                 q_full,
   output logic                                q_push,
   output gnce_pkg::box_type                   q_box
);

   localparam int NA   = gnce_pkg::NUM_AXES;
   localparam int CW   = gnce_pkg::CW;
   localparam int RW   = gnce_pkg::RW;
   localparam int EW   = gnce_pkg::EW;
   localparam int DW   = gnce_pkg::DW;
   localparam int PosW = gnce_pkg::POS_W;
   localparam int RadW = gnce_pkg::RAD_W;
   localparam int ProdW = gnce_pkg::PROD_W;
   localparam int FracW = gnce_pkg::FRAC_W;
   localparam int HiW  = ProdW - FracW;
   localparam int StepW = gnce_pkg::STEP_W;
   localparam int AxW  = gnce_pkg::AXW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_PUSH
   } state_type;

   state_type                       state_ff, state_in;
   logic [StepW-1:0]                step_ff, step_in;
   logic                            pvalid_ff, pvalid_in;
   logic [StepW-1:0]                pstep_ff, pstep_in;
   logic [ProdW-1:0]                prod_ff, prod_in;
   logic [NA-1:0][PosW-1:0]         pos_ff, pos_in;
   logic [RadW-1:0]                 radius_ff, radius_in;
   logic [NA-1:0][CW-1:0]           cell_ff, cell_in;
   logic [NA-1:0][RW-1:0]           reach_ff, reach_in;

   logic [AxW-1:0]                  mul_axis;
   logic [RadW-1:0]                 mul_a;
   logic [gnce_pkg::SCALE_W-1:0]    mul_b;
   logic [AxW-1:0]                  p_axis;
   logic [DW-1:0]                   p_dim;
   logic [HiW-1:0]                  p_hi;
   logic [HiW:0]                    p_ceil;
   logic [HiW-1:0]                  p_dlim;

   assign req_stall = (state_ff != ST_IDLE);

   // shared multiplier operands: even steps take the position, odd the radius
   assign mul_axis = step_ff[StepW-1:1];
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mul_axis)
         AxW'(gnce_pkg::AXIS_X): begin
            mul_a = step_ff[0] ? radius_ff : RadW'(pos_ff[gnce_pkg::AXIS_X]);
            mul_b = cfg.scale[gnce_pkg::AXIS_X];
         end
         AxW'(gnce_pkg::AXIS_Y): begin
            mul_a = step_ff[0] ? radius_ff : RadW'(pos_ff[gnce_pkg::AXIS_Y]);
            mul_b = cfg.scale[gnce_pkg::AXIS_Y];
         end
         AxW'(gnce_pkg::AXIS_Z): begin
            mul_a = step_ff[0] ? radius_ff : RadW'(pos_ff[gnce_pkg::AXIS_Z]);
            mul_b = cfg.scale[gnce_pkg::AXIS_Z];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // post-multiply view of the registered product
   assign p_axis = pstep_ff[StepW-1:1];
   assign p_hi   = prod_ff[ProdW-1:FracW];
   assign p_ceil = {1'b0, p_hi} + (HiW + 1)'(|prod_ff[FracW-1:0]);
   always_comb begin
      p_dim = '0;
      unique case (p_axis)
         AxW'(gnce_pkg::AXIS_X): p_dim = cfg.dim[gnce_pkg::AXIS_X];
         AxW'(gnce_pkg::AXIS_Y): p_dim = cfg.dim[gnce_pkg::AXIS_Y];
         AxW'(gnce_pkg::AXIS_Z): p_dim = cfg.dim[gnce_pkg::AXIS_Z];
         default:                p_dim = '0;
      endcase
   end
   assign p_dlim = HiW'(p_dim) - HiW'(1);

   // clamp cell box per axis
   always_comb begin
      logic [EW-1:0] c_e;
      logic [EW-1:0] r_e;
      logic [EW-1:0] lo_e;
      logic [EW-1:0] hi_e;
      logic [EW-1:0] d_e;
      q_box = '0;
      for (int a = 0; a < NA; a++) begin
         c_e  = EW'(cell_ff[a]);
         r_e  = EW'(reach_ff[a]);
         d_e  = EW'(cfg.dim[a]);
         lo_e = (c_e >= r_e) ? (c_e - r_e) : '0;
         hi_e = c_e + r_e;
         if (d_e == '0) begin
            hi_e = '0;
         end else if (hi_e > d_e - EW'(1)) begin
            hi_e = d_e - EW'(1);
         end
         q_box.lo[a] = CW'(lo_e);
         q_box.hi[a] = CW'(hi_e);
      end
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      pvalid_in = 1'b0;
      pstep_in  = pstep_ff;
      prod_in   = prod_ff;
      pos_in    = pos_ff;
      radius_in = radius_ff;
      cell_in   = cell_ff;
      reach_in  = reach_ff;
      q_push    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in[gnce_pkg::AXIS_X] = req_pos_x;
               pos_in[gnce_pkg::AXIS_Y] = req_pos_y;
               pos_in[gnce_pkg::AXIS_Z] = req_pos_z;
               radius_in = RadW'(req_reach_range) + RadW'(cfg.guard);
               step_in   = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == StepW'(gnce_pkg::NUM_STEPS)) begin
               state_in = ST_PUSH;
            end else begin
               prod_in   = ProdW'(mul_a * mul_b);
               pstep_in  = step_ff;
               pvalid_in = 1'b1;
               step_in   = step_ff + StepW'(1);
            end
         end
         ST_PUSH: begin
            q_push = !q_full;
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // fold the previous product into a cell index or a reach
      if (pvalid_ff) begin
         if (pstep_ff[0]) begin
            if (p_dim == '0) begin
               reach_in[p_axis] = '0;
            end else if (p_ceil > (HiW + 1)'(gnce_pkg::MAX_REACH)) begin
               reach_in[p_axis] = RW'(gnce_pkg::MAX_REACH);
            end else begin
               reach_in[p_axis] = RW'(p_ceil);
            end
         end else begin
            if (p_dim == '0) begin
               cell_in[p_axis] = '0;
            end else if (p_hi > p_dlim) begin
               cell_in[p_axis] = CW'(p_dlim);
            end else begin
               cell_in[p_axis] = CW'(p_hi);
            end
         end
      end
   end

   // state and working registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      pstep_ff  <= pstep_in;
      prod_ff   <= prod_in;
      pos_ff    <= pos_in;
      radius_ff <= radius_in;
      cell_ff   <= cell_in;
      reach_ff  <= reach_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         pvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pvalid_ff <= pvalid_in;
      end
   end

`ifndef ASSERT_OFF
   // a pushed box is never empty on any axis
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_box.lo[0] <= q_box.hi[0]) && (q_box.lo[1] <= q_box.hi[1])
                 && (q_box.lo[2] <= q_box.hi[2]))
      else $error("front pushed an empty box");
`endif

endmodule

`default_nettype wire

FILE: src/gnce_queue.sv
// ----------------------------------------------------------------------------
// gnce_queue: box queue between front and back
// Small first-in first-out store of cell boxes so that the front can set up
// the next query while the back is still walking the current one.
// ----------------------------------------------------------------------------
`default_nettype none

module gnce_queue #(
   parameter int DEPTH = gnce_pkg::QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire gnce_pkg::box_type push_box,
   input  wire                    pop,
   output gnce_pkg::box_type      head_box,
   output logic                   full,
   output logic                   empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   gnce_pkg::box_type entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_box = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_box;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   // no push into a full queue, no pop from an empty one
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue underflow");
   // fill count follows the pointers
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CntW'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with count");
`endif

endmodule

`default_nettype wire

FILE: src/gnce_back.sv
// ----------------------------------------------------------------------------
// gnce_back: cell box walker
// Pops one box at a time and emits every cell in it in row-major order, x outermost
// and z innermost, one word per cycle into the output register while it is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module gnce_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire gnce_pkg::cfg_type       cfg,
   input  wire                          q_empty,
   input  wire gnce_pkg::box_type       q_box,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [gnce_pkg::ID_W-1:0]    rsp_cell_id,
   output logic [gnce_pkg::COORD_W-1:0] rsp_cell_x,
   output logic [gnce_pkg::COORD_W-1:0] rsp_cell_y,
   output logic [gnce_pkg::COORD_W-1:0] rsp_cell_z,
   output logic                         rsp_last_cell
);

   localparam int CW    = gnce_pkg::CW;
   localparam int DW    = gnce_pkg::DW;
   localparam int IdW   = gnce_pkg::ID_W;
   localparam int CoordW = gnce_pkg::COORD_W;
   localparam int StrW  = 2 * DW;
   localparam int IdFullW = CW + StrW + 1;
   localparam int AX    = gnce_pkg::AXIS_X;
   localparam int AY    = gnce_pkg::AXIS_Y;
   localparam int AZ    = gnce_pkg::AXIS_Z;

   logic                 active_ff, active_in;
   gnce_pkg::box_type    box_ff, box_in;
   logic [CW-1:0]        cur_x_ff, cur_x_in;
   logic [CW-1:0]        cur_y_ff, cur_y_in;
   logic [CW-1:0]        cur_z_ff, cur_z_in;
   logic [StrW-1:0]      stride_x_ff, stride_x_in;
   logic [DW-1:0]        stride_y_ff, stride_y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IdW-1:0]       id_ff, id_in;
   logic [CoordW-1:0]    x_ff, x_in;
   logic [CoordW-1:0]    y_ff, y_in;
   logic [CoordW-1:0]    z_ff, z_in;
   logic                 last_ff, last_in;

   logic                 load_out;
   logic                 emit;
   logic                 at_last;
   logic [DW-1:0]        size_y;
   logic [DW-1:0]        size_z;
   logic [IdFullW-1:0]   id_full;

   // an unused axis counts as one cell
   assign size_y = (cfg.dim[AY] == '0) ? DW'(1) : cfg.dim[AY];
   assign size_z = (cfg.dim[AZ] == '0) ? DW'(1) : cfg.dim[AZ];

   assign load_out = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && load_out;
   assign q_pop    = !active_ff && !q_empty;
   assign at_last  = (cur_x_ff == box_ff.hi[AX]) && (cur_y_ff == box_ff.hi[AY])
                     && (cur_z_ff == box_ff.hi[AZ]);
   assign id_full  = IdFullW'(cur_x_ff) * IdFullW'(stride_x_ff)
                     + IdFullW'(cur_y_ff) * IdFullW'(stride_y_ff)
                     + IdFullW'(cur_z_ff);

   // walker and output register next state
   always_comb begin
      active_in    = active_ff;
      box_in       = box_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_z_in     = cur_z_ff;
      stride_x_in  = stride_x_ff;
      stride_y_in  = stride_y_ff;
      rsp_valid_in = rsp_valid_ff;
      id_in        = id_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      last_in      = last_ff;

      if (load_out) begin
         rsp_valid_in = active_ff;
      end

      if (q_pop) begin
         // start a new box at its low corner
         active_in   = 1'b1;
         box_in      = q_box;
         cur_x_in    = q_box.lo[AX];
         cur_y_in    = q_box.lo[AY];
         cur_z_in    = q_box.lo[AZ];
         stride_x_in = StrW'(size_y) * StrW'(size_z);
         stride_y_in = size_z;
      end else if (emit) begin
         id_in   = IdW'(id_full);
         x_in    = CoordW'(cur_x_ff);
         y_in    = CoordW'(cur_y_ff);
         z_in    = CoordW'(cur_z_ff);
         last_in = at_last;
         // step z fastest, then y, then x
         if (at_last) begin
            active_in = 1'b0;
         end else if (cur_z_ff != box_ff.hi[AZ]) begin
            cur_z_in = cur_z_ff + CW'(1);
         end else if (cur_y_ff != box_ff.hi[AY]) begin
            cur_z_in = box_ff.lo[AZ];
            cur_y_in = cur_y_ff + CW'(1);
         end else begin
            cur_z_in = box_ff.lo[AZ];
            cur_y_in = box_ff.lo[AY];
            cur_x_in = cur_x_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ff      <= box_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_z_ff    <= cur_z_in;
      stride_x_ff <= stride_x_in;
      stride_y_ff <= stride_y_in;
      id_ff       <= id_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      last_ff     <= last_in;
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_id   = id_ff;
   assign rsp_cell_x    = x_ff;
   assign rsp_cell_y    = y_ff;
   assign rsp_cell_z    = z_ff;
   assign rsp_last_cell = last_ff;

`ifndef ASSERT_OFF
   // the cursor stays inside the box while walking
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cur_x_ff >= box_ff.lo[AX]) && (cur_x_ff <= box_ff.hi[AX])
                    && (cur_y_ff >= box_ff.lo[AY]) && (cur_y_ff <= box_ff.hi[AY])
                    && (cur_z_ff >= box_ff.lo[AZ]) && (cur_z_ff <= box_ff.hi[AZ]))
      else $error("cursor left the box");
   // the last cell of a box ends the walk
   assert property (@(posedge clock) disable iff (reset)
      (emit && at_last) |=> !active_ff && rsp_valid_ff && rsp_last_cell)
      else $error("walk did not end on the last cell");
`endif

endmodule

`default_nettype wire

FILE: src/grid_neighbor_cell_enumerator_unit.sv
// ----------------------------------------------------------------------------
// grid_neighbor_cell_enumerator_unit: uniform-grid neighbor cell enumerator
// Maps a query position to a 3D grid cell, widens it by the reach in cells
// and lists every cell of the clamped box with its row-major id.
// ----------------------------------------------------------------------------
//   csr_*  : plain write port for dims, per-axis scales and guard distance;
//            write only while no query is in flight.
//   req_*  : one query word (position and range), taken when req_valid is
//            high and req_stall is low; the front takes no new query until it
//            has run six products through one shared 24x25 multiplier and pushed the box.
//   rsp_*  : one word per cell of the box, 1 to 27 words per query, the final
//            one flagged by rsp_last_cell; taken when rsp_valid && !rsp_stall.
// An accepted query runs its multiply steps and then pushes its box; the walker loads
//   each box before its first cell and then emits one cell per cycle while the output
//   is not stalled.
// Reset clears all control state, the queue and the output valid flag, and
//   loads the register defaults (16 x 16 grid, z unused, scale 1/256 cell per unit, no guard).
// A stalled receiver holds the output word; the walker and then the two-entry
//   box queue fill, after which req_stall stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_neighbor_cell_enumerator_unit #(
   parameter int QUEUE_DEPTH = gnce_pkg::QUEUE_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_write,
   input  wire [gnce_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [gnce_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [gnce_pkg::POS_W-1:0]        req_pos_x,
   input  wire [gnce_pkg::POS_W-1:0]        req_pos_y,
   input  wire [gnce_pkg::POS_W-1:0]        req_pos_z,
   input  wire [gnce_pkg::POS_W-1:0]        req_reach_range,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [gnce_pkg::ID_W-1:0]        rsp_cell_id,
   output logic [gnce_pkg::COORD_W-1:0]     rsp_cell_x,
   output logic [gnce_pkg::COORD_W-1:0]     rsp_cell_y,
   output logic [gnce_pkg::COORD_W-1:0]     rsp_cell_z,
   output logic                             rsp_last_cell
);

   localparam int DimRegW = gnce_pkg::DIM_REG_W;
   localparam int ScaleW  = gnce_pkg::SCALE_W;
   localparam int DW      = gnce_pkg::DW;

   logic [DimRegW-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [ScaleW-1:0]  scale_x_ff, scale_y_ff, scale_z_ff;
   logic [ScaleW-1:0]  guard_ff;

   gnce_pkg::cfg_type  cfg;
   gnce_pkg::box_type  push_box;
   gnce_pkg::box_type  head_box;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff   <= gnce_pkg::DIM_X_RST;
         dim_y_ff   <= gnce_pkg::DIM_Y_RST;
         dim_z_ff   <= gnce_pkg::DIM_Z_RST;
         scale_x_ff <= gnce_pkg::SCALE_RST;
         scale_y_ff <= gnce_pkg::SCALE_RST;
         scale_z_ff <= gnce_pkg::SCALE_RST;
         guard_ff   <= gnce_pkg::GUARD_RST;
      end else if (csr_write) begin
         unique case (gnce_pkg::csr_reg_type'(csr_index))
            gnce_pkg::REG_DIM_X:   dim_x_ff   <= csr_data[DimRegW-1:0];
            gnce_pkg::REG_DIM_Y:   dim_y_ff   <= csr_data[DimRegW-1:0];
            gnce_pkg::REG_DIM_Z:   dim_z_ff   <= csr_data[DimRegW-1:0];
            gnce_pkg::REG_SCALE_X: scale_x_ff <= csr_data[ScaleW-1:0];
            gnce_pkg::REG_SCALE_Y: scale_y_ff <= csr_data[ScaleW-1:0];
            gnce_pkg::REG_SCALE_Z: scale_z_ff <= csr_data[ScaleW-1:0];
            gnce_pkg::REG_GUARD:   guard_ff   <= csr_data[ScaleW-1:0];
            default: ;
         endcase
      end
   end

   // dims above the grid limit act as the limit
   function automatic logic [DW-1:0] clamp_dim(input logic [DimRegW-1:0] d);
      logic [DW-1:0] r;
      if (32'(d) > gnce_pkg::MAX_DIM) begin
         r = DW'(gnce_pkg::MAX_DIM);
      end else begin
         r = DW'(d);
      end
      return r;
   endfunction

   assign cfg.dim[gnce_pkg::AXIS_X]   = clamp_dim(dim_x_ff);
   assign cfg.dim[gnce_pkg::AXIS_Y]   = clamp_dim(dim_y_ff);
   assign cfg.dim[gnce_pkg::AXIS_Z]   = clamp_dim(dim_z_ff);
   assign cfg.scale[gnce_pkg::AXIS_X] = scale_x_ff;
   assign cfg.scale[gnce_pkg::AXIS_Y] = scale_y_ff;
   assign cfg.scale[gnce_pkg::AXIS_Z] = scale_z_ff;
   assign cfg.guard                   = guard_ff;

   // query intake and box setup
   gnce_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_reach_range (req_reach_range),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_box           (push_box)
   );

   // box queue
   gnce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_box (push_box),
      .pop      (q_pop),
      .head_box (head_box),
      .full     (q_full),
      .empty    (q_empty)
   );

   // cell walker
   gnce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_empty       (q_empty),
      .q_box         (head_box),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_id   (rsp_cell_id),
      .rsp_cell_x    (rsp_cell_x),
      .rsp_cell_y    (rsp_cell_y),
      .rsp_cell_z    (rsp_cell_z),
      .rsp_last_cell (rsp_last_cell)
   );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the grid neighbor cell enumerator
// Sends query words (position and range) under several grid, scale and guard
// settings, predicts the cell box of each accepted query and checks every
// cell word in order. Both sides pause at random. In one phase the receiver
// holds off for a long stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gnce_pkg::*;

   localparam int FRACTION    = 24;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int GAP_PERCENT = 13;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [POS_W-1:0] span;
   } query_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last;
   } cell_type;

   // block ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_DIM_X;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [POS_W-1:0]      req_pos_x = '0;
   logic [POS_W-1:0]      req_pos_y = '0;
   logic [POS_W-1:0]      req_pos_z = '0;
   logic [POS_W-1:0]      req_reach_range = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ID_W-1:0]       rsp_cell_id;
   logic [COORD_W-1:0]    rsp_cell_x;
   logic [COORD_W-1:0]    rsp_cell_y;
   logic [COORD_W-1:0]    rsp_cell_z;
   logic                  rsp_last_cell;

   // bench state
   query_type pending_queries [$];
   cell_type  expected_cells [$];
   int        errors = 0;
   logic      sender_steady = 1'b0;
   logic      receiver_steady = 1'b0;
   logic      hold_armed = 1'b0;
   logic      hold_started = 1'b0;
   int        hold_left = 0;

   // shadow copy of the grid registers, reset values
   logic [DIM_REG_W-1:0] grid_dim [3] = '{5'd16, 5'd16, 5'd0};
   logic [SCALE_W-1:0]   grid_scale [3] = '{24'd65536, 24'd65536, 24'd65536};
   logic [SCALE_W-1:0]   guard_dist = '0;

   grid_neighbor_cell_enumerator_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_reach_range (req_reach_range),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_id     (rsp_cell_id),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_cell_z      (rsp_cell_z),
      .rsp_last_cell   (rsp_last_cell)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // box of one query, every cell queued in emission order
   task automatic predict_cells(input query_type q);
      logic [63:0] pos [3];
      logic [63:0] eff [3];
      logic [63:0] radius, prod, c, r, h;
      int          lo [3];
      int          hi [3];
      int          size_y, size_z, total, count;
      cell_type    next_word;
      pos[0] = 64'(q.pos_x);
      pos[1] = 64'(q.pos_y);
      pos[2] = 64'(q.pos_z);
      radius = 64'(q.span) + 64'(guard_dist);
      for (int ax = 0; ax < 3; ax++) begin
         eff[ax] = 64'(grid_dim[ax]);
         if (eff[ax] > 64'(MAX_DIM)) eff[ax] = 64'(MAX_DIM);
         if (eff[ax] == 0) begin
            c = 0;
            r = 0;
         end else begin
            // floor of the scaled position, clamped at the top edge
            prod = (pos[ax] * 64'(grid_scale[ax])) >> FRACTION;
            c = (prod > eff[ax] - 1) ? eff[ax] - 1 : prod;
            // reach rounded up to whole cells, saturated
            prod = (radius * 64'(grid_scale[ax]) + ((64'd1 << FRACTION) - 1)) >> FRACTION;
            r = (prod > 64'(MAX_REACH)) ? 64'(MAX_REACH) : prod;
         end
         lo[ax] = (c >= r) ? int'(c - r) : 0;
         h = c + r;
         if (eff[ax] == 0) h = 0;
         else if (h > eff[ax] - 1) h = eff[ax] - 1;
         hi[ax] = int'(h);
      end
      size_y = (eff[1] == 0) ? 1 : int'(eff[1]);
      size_z = (eff[2] == 0) ? 1 : int'(eff[2]);
      total = (hi[0] - lo[0] + 1) * (hi[1] - lo[1] + 1) * (hi[2] - lo[2] + 1);
      count = 0;
      for (int x = lo[0]; x <= hi[0]; x++) begin
         for (int y = lo[1]; y <= hi[1]; y++) begin
            for (int z = lo[2]; z <= hi[2]; z++) begin
               count++;
               next_word.id   = ID_W'(x * size_y * size_z + y * size_z + z);
               next_word.x    = COORD_W'(x);
               next_word.y    = COORD_W'(y);
               next_word.z    = COORD_W'(z);
               next_word.last = (count == total);
               expected_cells.insert(expected_cells.size(), next_word);
            end
         end
      end
   endtask

   // query driver: predict on accept, then offer the next word or idle
   always @(posedge clock) begin : query_driver
      query_type q;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            q.pos_x = req_pos_x;
            q.pos_y = req_pos_y;
            q.pos_z = req_pos_z;
            q.span  = req_reach_range;
            predict_cells(q);
         end
         if (!req_valid || !req_stall) begin
            if (pending_queries.size() != 0 &&
                (sender_steady || $urandom_range(99) >= GAP_PERCENT)) begin
               q = pending_queries.pop_front();
               req_valid       <= 1'b1;
               req_pos_x       <= q.pos_x;
               req_pos_y       <= q.pos_y;
               req_pos_z       <= q.pos_z;
               req_reach_range <= q.span;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      end
   endtask

   // cell checker: compare each accepted word, then pick the next stall
   always @(posedge clock) begin : cell_checker
      cell_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               errors++;
               $display("%0t: unexpected cell word: expected none, actual id %0d (%0d,%0d,%0d)",
                        $time, rsp_cell_id, rsp_cell_x, rsp_cell_y, rsp_cell_z);
            end else begin
               want = expected_cells.pop_front();
               check_field("cell_id", want.id, rsp_cell_id);
               check_field("cell_x", want.x, rsp_cell_x);
               check_field("cell_y", want.y, rsp_cell_y);
               check_field("cell_z", want.z, rsp_cell_z);
               check_field("last_cell", want.last, rsp_last_cell);
            end
         end
         if (hold_armed && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !receiver_steady && ($urandom_range(99) < GAP_PERCENT);
         end
      end
   end

   // one register write, taken at the next edge; caller lowers the enable
   task automatic write_register(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         REG_DIM_X:   grid_dim[0] = value[DIM_REG_W-1:0];
         REG_DIM_Y:   grid_dim[1] = value[DIM_REG_W-1:0];
         REG_DIM_Z:   grid_dim[2] = value[DIM_REG_W-1:0];
         REG_SCALE_X: grid_scale[0] = value;
         REG_SCALE_Y: grid_scale[1] = value;
         REG_SCALE_Z: grid_scale[2] = value;
         REG_GUARD:   guard_dist = value;
         default: ;
      endcase
   endtask

   task automatic program_grid(input logic [CSR_DATA_W-1:0] dx, dy, dz, sx, sy, sz, g);
      write_register(REG_DIM_X, dx);
      write_register(REG_DIM_Y, dy);
      write_register(REG_DIM_Z, dz);
      write_register(REG_SCALE_X, sx);
      write_register(REG_SCALE_Y, sy);
      write_register(REG_SCALE_Z, sz);
      write_register(REG_GUARD, g);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_query(input logic [POS_W-1:0] px, py, pz, span);
      query_type q;
      q.pos_x = px;
      q.pos_y = py;
      q.pos_z = pz;
      q.span  = span;
      pending_queries.insert(pending_queries.size(), q);
   endtask

   function automatic logic [POS_W-1:0] rand_pos();
      case ($urandom_range(3))
         0:       return POS_W'($urandom_range(20 * 256));
         1:       return POS_W'($urandom);
         2:       return $urandom_range(1) ? '1 : '0;
         default: return POS_W'($urandom_range(4095));
      endcase
   endfunction

   function automatic logic [POS_W-1:0] rand_span();
      case ($urandom_range(4))
         0:       return '0;
         1:       return POS_W'($urandom_range(1, 600));
         2:       return POS_W'($urandom);
         3:       return '1;
         default: return POS_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_dim();
      logic [CSR_DATA_W-1:0] v;
      v = ($urandom_range(5) == 0) ? CSR_DATA_W'($urandom_range(17, 31))
                                   : CSR_DATA_W'($urandom_range(16));
      // upper bits are outside the register and must be dropped
      if ($urandom_range(1)) v = v | (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(5'h1f));
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_scale();
      case ($urandom_range(4))
         0:       return CSR_DATA_W'(65536);
         1:       return CSR_DATA_W'($urandom_range(24'h3ffff));
         2:       return CSR_DATA_W'($urandom);
         3:       return '0;
         default: return CSR_DATA_W'($urandom_range(24'h8000, 24'h30000));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_guard();
      case ($urandom_range(2))
         0:       return '0;
         1:       return CSR_DATA_W'($urandom_range(1024));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) queue_query(rand_pos(), rand_pos(), rand_pos(), rand_span());
   endtask

   // wait for every query to be taken and every cell to arrive, then settle
   task automatic finish_phase();
      while (pending_queries.size() != 0 || req_valid || expected_cells.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 16 x 16 grid, z unused, scale 1/256 cell per unit
      queue_query(24'd0, 24'd0, 24'd0, 24'd0);
      queue_query(24'd0, 24'd0, 24'd0, 24'd1);
      queue_query('1, '1, '1, '1);
      queue_query(24'd2176, 24'd2176, 24'd2176, 24'd256);
      queue_query(24'd3840, 24'd3840, 24'd0, 24'd255);
      queue_query(24'd4096, 24'd4096, 24'd4096, 24'd0);
      queue_query(24'd256, 24'd256, 24'd0, 24'd256);
      queue_query(24'h800000, 24'd0, 24'h555555, 24'haaaaaa);
      finish_phase();

      // full 3d grid, no pauses on either side
      program_grid(24'd16, 24'd16, 24'd16, 24'd65536, 24'd65536, 24'd65536, 24'd0);
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      queue_query(24'd2176, 24'd1280, 24'd3000, 24'd256);
      queue_query(24'd0, 24'd0, 24'd0, 24'd256);
      queue_query('1, '1, '1, 24'd256);
      queue_query(24'd3839, 24'd255, 24'd3840, 24'd0);
      queue_random(50);
      finish_phase();
      receiver_steady = 1'b0;

      // oversized dims, receiver holds off while the sender keeps going
      program_grid(24'd31, 24'hffffff, 24'd17, 24'd65536, 24'd65536, 24'd65536, 24'd0);
      queue_query('1, 24'd1000, 24'd4096, 24'd256);
      queue_random(40);
      hold_armed = 1'b1;
      finish_phase();
      sender_steady = 1'b0;

      // every axis unused
      program_grid(24'd0, 24'd0, 24'd0, 24'd65536, 24'd65536, 24'd65536, 24'd0);
      queue_query('1, '1, '1, '1);
      queue_random(20);
      finish_phase();

      // single cell per axis and zero scale
      program_grid(24'd1, 24'd1, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0);
      queue_query('1, '1, '1, '1);
      queue_random(20);
      finish_phase();

      // largest scale and guard
      program_grid(24'd16, 24'd16, 24'd16, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
      queue_query(24'd0, 24'd0, 24'd0, 24'd0);
      queue_query(24'd1, 24'd1, 24'd1, 24'd0);
      queue_random(30);
      finish_phase();

      // random settings
      for (int p = 0; p < 6; p++) begin
         program_grid(rand_dim(), rand_dim(), rand_dim(),
                      rand_scale(), rand_scale(), rand_scale(), rand_guard());
         queue_random(40);
         finish_phase();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
